>>> hdl/sobel_edge_magnitude_unit_assert.svh
// Assertion macros shared by the edge magnitude design.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/sem_pkg.sv
package sem_pkg;
    localparam int unsigned PixW = 8;
    localparam int unsigned GeoW = 11;
    localparam int unsigned SensW = 16;
    localparam int unsigned HeightLimit = 1024;
    localparam int unsigned SqrtInW = 32;
    localparam int unsigned RootW = 16;

    typedef enum logic [1:0] {
        REG_WIDTH = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_SENS = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROOT,
        ST_SCALE
    } t_state;

    // One result's 3x3 neighborhood after masking, top row first.
    typedef struct packed {
        logic [8:0][PixW-1:0] pix;
        logic                 last;
    } t_win;
endpackage

>>> hdl/sobel_edge_magnitude_unit.sv
// Sequential: an item with a result passes read, 16 root steps, scale and the output
// register before the next acceptance, and waits longer while the result is held;
// an item without a result passes only the read state, and an ignored flush stays idle.
// The item that causes a result follows its pixel by one row plus one pixel.
// Synchronous active-low reset clears control and loads the default geometry and gain,
// then a clearing pass zeroes every entry of the line memories.
module sobel_edge_magnitude_unit
    import sem_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [SensW-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PixW-1:0]  i_pixel_value,
    input  logic             i_is_flush,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PixW-1:0]  o_edge_value,
    output logic             o_last_of_frame
);
    `include "sobel_edge_magnitude_unit_assert.svh"

    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned CW = AW + 1;

    logic [GeoW-1:0]  r_fw, r_fh;
    logic [SensW-1:0] r_sens;
    logic [PixW-1:0]  r_up [MAX_WIDTH];
    logic [PixW-1:0]  r_mid [MAX_WIDTH];
    logic [PixW-1:0]  r_up_q, r_mid_q;
    logic [8:0][PixW-1:0] r_win;
    logic [CW-1:0]    r_col;
    logic [GeoW:0]    r_row;
    logic [CW:0]      r_fill;
    logic [AW-1:0]    r_clr;
    logic [AW-1:0]    r_addr;
    logic [PixW-1:0]  r_v;
    logic             r_emit, r_c0, r_topok, r_botok, r_lok, r_lastp;
    t_state           r_st, n_st;
    logic             r_ov;
    logic [PixW-1:0]  r_oe;
    logic             r_ol;
    logic             w_done, w_last;
    logic [PixW-1:0]  w_edge;
    t_win             w_win;
    logic             w_start;

    logic [CW-1:0] w_w;
    logic [GeoW:0] w_h;
    always_comb begin
        if (r_fw == '0) w_w = CW'(1);
        else if (32'(r_fw) > MAX_WIDTH) w_w = CW'(MAX_WIDTH);
        else w_w = CW'(r_fw);
        if (r_fh == '0) w_h = 12'd1;
        else if (r_fh > GeoW'(HeightLimit)) w_h = 12'(HeightLimit);
        else w_h = {1'b0, r_fh};
    end

    // Per-item decode, as in the item flow.
    logic          w_acc, w_skip, w_newf, w_drop, w_emit;
    logic [CW-1:0] w_ci;
    logic [GeoW:0] w_ri;
    logic signed [GeoW+1:0] w_ro, w_rr, w_hs;
    logic [CW-1:0] w_co;
    always_comb begin
        w_acc = i_valid && o_ready;
        w_skip = i_is_flush && (r_row < w_h);
        w_newf = !i_is_flush && (r_row >= w_h);
        w_drop = w_newf && !(r_row == w_h && r_col == '0);
        w_ri = w_newf ? '0 : r_row;
        w_ci = (w_newf || r_col >= w_w) ? '0 : r_col;
        w_emit = !w_drop && (r_fill > {1'b0, w_w});
        if (w_ci == '0) begin
            w_ro = 13'(signed'({1'b0, w_ri})) - 13'sd2;
            w_co = w_w - CW'(1);
        end else begin
            w_ro = 13'(signed'({1'b0, w_ri})) - 13'sd1;
            w_co = w_ci - CW'(1);
        end
        // A one-row frame needs the row index wrapped twice.
        w_hs = 13'(signed'({1'b0, w_h}));
        w_rr = w_ro;
        if (w_rr < 0) w_rr = w_rr + w_hs;
        if (w_rr < 0) w_rr = w_rr + w_hs;
    end

    // Control sequence of one transaction.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR: if (r_clr == AW'(MAX_WIDTH - 1)) n_st = ST_IDLE;
            ST_IDLE:  if (w_acc && !w_skip) n_st = ST_READ;
            ST_READ:  n_st = r_emit ? ST_ROOT : ST_IDLE;
            ST_ROOT:  if (w_done) n_st = ST_SCALE;
            ST_SCALE: if (!r_ov || i_ready) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_st == ST_IDLE) && !i_cfg_we;
        w_start = (r_st == ST_READ) && r_emit;
    end

    // Line memories: cleared after reset, read at the column, written back next cycle.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && w_acc && !w_skip) begin
            r_up_q <= r_up[w_ci[AW-1:0]];
            r_mid_q <= r_mid[w_ci[AW-1:0]];
        end
        if (r_st == ST_CLEAR) begin
            r_up[r_clr] <= '0;
            r_mid[r_clr] <= '0;
        end else if (r_st == ST_READ) begin
            r_up[r_addr] <= r_mid_q;
            r_mid[r_addr] <= r_v;
        end
    end

    // Window shift with masked gather for the result.
    always_comb begin
        w_win.last = r_lastp;
        for (int r = 0; r < 3; r++) begin
            if (r_c0) begin
                w_win.pix[r*3+0] = r_lok ? r_win[r*3+1] : '0;
                w_win.pix[r*3+1] = r_win[r*3+2];
                w_win.pix[r*3+2] = '0;
            end else begin
                w_win.pix[r*3+0] = r_lok ? r_win[r*3+2] : '0;
                w_win.pix[r*3+1] = (r == 0) ? r_up_q : (r == 1) ? r_mid_q : r_v;
                w_win.pix[r*3+2] = '0;
            end
        end
        if (!r_c0) begin
            w_win.pix[0] = r_lok ? r_win[1] : '0;
            w_win.pix[1] = r_win[2];
            w_win.pix[2] = r_up_q;
            w_win.pix[3] = r_lok ? r_win[4] : '0;
            w_win.pix[4] = r_win[5];
            w_win.pix[5] = r_mid_q;
            w_win.pix[6] = r_lok ? r_win[7] : '0;
            w_win.pix[7] = r_win[8];
            w_win.pix[8] = r_v;
        end
        if (!r_topok) begin
            w_win.pix[0] = '0; w_win.pix[1] = '0; w_win.pix[2] = '0;
        end
        if (!r_botok) begin
            w_win.pix[6] = '0; w_win.pix[7] = '0; w_win.pix[8] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 11'd640;
            r_fh <= 11'd480;
            r_sens <= 16'd256;
            r_st <= ST_CLEAR;
            r_clr <= '0;
            r_col <= '0;
            r_row <= '0;
            r_fill <= '0;
            r_win <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH: begin
                        r_fw <= i_cfg_data[GeoW-1:0];
                        r_col <= '0; r_row <= '0; r_fill <= '0;
                    end
                    REG_HEIGHT: begin
                        r_fh <= i_cfg_data[GeoW-1:0];
                        r_col <= '0; r_row <= '0; r_fill <= '0;
                    end
                    REG_SENS: r_sens <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == ST_IDLE && w_acc && !w_skip) begin
                r_addr <= w_ci[AW-1:0];
                r_v <= i_is_flush ? '0 : i_pixel_value;
                r_emit <= w_emit;
                r_c0 <= (w_ci == '0);
                r_topok <= (w_rr >= 1);
                r_botok <= (w_rr + 13'sd1 < 13'(signed'({1'b0, w_h})));
                r_lok <= (w_ci == '0) ? (w_w >= CW'(2)) : (w_ci >= CW'(2));
                r_lastp <= w_emit && (w_rr == 13'(signed'({1'b0, w_h})) - 13'sd1)
                           && (w_co == w_w - CW'(1));
                if (!w_emit) r_fill <= (w_drop ? '0 : r_fill) + 1'b1;
                if (w_emit && (w_rr == 13'(signed'({1'b0, w_h})) - 13'sd1)
                        && (w_co == w_w - CW'(1)) && w_ro >= 0) begin
                    r_fill <= '0; r_row <= '0; r_col <= '0;
                end else if (w_ci + CW'(1) >= w_w) begin
                    r_col <= '0; r_row <= w_ri + 1'b1;
                end else begin
                    r_col <= w_ci + CW'(1); r_row <= w_ri;
                end
            end
            if (r_st == ST_READ) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3+0] <= r_win[r*3+1];
                    r_win[r*3+1] <= r_win[r*3+2];
                end
                r_win[2] <= r_up_q;
                r_win[5] <= r_mid_q;
                r_win[8] <= r_v;
            end
            if (w_done) begin
                r_ov <= 1'b1;
                r_oe <= w_edge;
                r_ol <= w_last;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    sem_magnitude u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_win   (w_win),
        .i_sens  (r_sens),
        .o_done  (w_done),
        .o_edge  (w_edge),
        .o_last  (w_last)
    );

    assign o_valid = r_ov;
    assign o_edge_value = r_oe;
    assign o_last_of_frame = r_ol;

    `SEM_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_st == ST_IDLE)
    `SEM_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, w_done, o_valid)
    `SEM_ASSERT_IMP(a_col_range, i_clk, i_rst_n, r_st == ST_READ, r_col <= w_w)
endmodule

>>> hdl/sem_magnitude.sv
// Gradient magnitude: Sobel sums, bit-serial root, gain and saturation.
module sem_magnitude
    import sem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_win             i_win,
    input  logic [SensW-1:0] i_sens,
    output logic             o_done,
    output logic [PixW-1:0]  o_edge,
    output logic             o_last
);
    `include "sobel_edge_magnitude_unit_assert.svh"

    logic signed [11:0] w_gx, w_gy;
    logic signed [23:0] w_gxe, w_gye, w_g2;
    logic [SqrtInW-1:0] w_g2s;
    logic [RootW-1:0]   r_root;
    logic [3:0]         r_step;
    logic               r_busy, r_mul;
    logic               r_last;
    logic [RootW+SensW-1:0] r_prod;

    // Sobel sums over the masked window.
    always_comb begin
        w_gx = 12'(signed'({1'b0, i_win.pix[2]})) - 12'(signed'({1'b0, i_win.pix[0]}))
             + 12'(signed'({1'b0, i_win.pix[5]})) * 12'sd2
             - 12'(signed'({1'b0, i_win.pix[3]})) * 12'sd2
             + 12'(signed'({1'b0, i_win.pix[8]})) - 12'(signed'({1'b0, i_win.pix[6]}));
        w_gy = 12'(signed'({1'b0, i_win.pix[6]})) - 12'(signed'({1'b0, i_win.pix[0]}))
             + 12'(signed'({1'b0, i_win.pix[7]})) * 12'sd2
             - 12'(signed'({1'b0, i_win.pix[1]})) * 12'sd2
             + 12'(signed'({1'b0, i_win.pix[8]})) - 12'(signed'({1'b0, i_win.pix[2]}));
        w_gxe = 24'(w_gx);
        w_gye = 24'(w_gy);
        w_g2 = w_gxe * w_gxe + w_gye * w_gye;
        w_g2s = {w_g2, 8'd0};
    end

    // One root bit per cycle, restoring form.
    logic [SqrtInW-1:0] r_x;
    logic [SqrtInW+1:0] r_r2;
    logic [SqrtInW+1:0] w_acc, w_sub;
    always_comb begin
        w_acc = {r_r2[SqrtInW-1:0], r_x[SqrtInW-1 -: 2]};
        w_sub = w_acc - {16'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x <= w_g2s;
                r_r2 <= '0;
                r_root <= '0;
                r_step <= '0;
                r_last <= i_win.last;
            end else if (r_busy) begin
                r_x <= {r_x[SqrtInW-3:0], 2'b00};
                if (!w_sub[SqrtInW+1]) begin
                    r_r2 <= w_sub;
                    r_root <= {r_root[RootW-2:0], 1'b1};
                end else begin
                    r_r2 <= w_acc;
                    r_root <= {r_root[RootW-2:0], 1'b0};
                end
                r_step <= r_step + 4'd1;
                if (r_step == 4'd15) begin
                    r_busy <= 1'b0;
                    r_mul <= 1'b1;
                end
            end else if (r_mul) begin
                r_mul <= 1'b0;
                r_prod <= r_root * i_sens;
                o_done <= 1'b1;
            end
        end
    end

    logic [RootW+SensW:0] w_rnd;
    always_comb begin
        w_rnd = {1'b0, r_prod} + 33'd2048;
        o_edge = (|w_rnd[RootW+SensW:20]) ? 8'hFF : w_rnd[19:12];
        o_last = r_last;
    end

    `SEM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy)
    `SEM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, i_start, !r_busy && !r_mul)
    `SEM_ASSERT_NEXT(a_mul_done, i_clk, i_rst_n, r_mul, o_done)
endmodule

>>> sim/sobel_edge_magnitude_unit_test.sv
module sobel_edge_magnitude_unit_test;
    import sem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int unsigned LineMax = 1024;
    localparam int unsigned DrainCycles = 60;
    localparam int unsigned WatchLimit = 5000;
    localparam int unsigned LongHold = 400;

    typedef struct packed {
        logic [PixW-1:0] edge_v;
        logic            last;
    } t_edge_res;

    // Scoreboard: tracks the block's state and queues the expected edge results.
    class edge_scoreboard;
        int unsigned width_reg, height_reg, sens_reg;
        bit [7:0] upper[LineMax];
        bit [7:0] middle[LineMax];
        bit [7:0] win[9];
        int unsigned col, row, emitted, fill;
        t_edge_res expected_q[$];
        int unsigned errors, results_seen;

        function new();
            width_reg = 640;
            height_reg = 480;
            sens_reg = 256;
            foreach (upper[k]) begin
                upper[k] = 0;
                middle[k] = 0;
            end
            foreach (win[k]) win[k] = 0;
            restart();
            errors = 0;
            results_seen = 0;
        endfunction

        function void restart();
            col = 0;
            row = 0;
            emitted = 0;
            fill = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > LineMax) return LineMax;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > HeightLimit) return HeightLimit;
            return height_reg;
        endfunction

        function void configure(logic [1:0] idx, logic [15:0] val);
            if (idx == REG_WIDTH) begin
                width_reg = val & 16'h7FF;
                restart();
            end else if (idx == REG_HEIGHT) begin
                height_reg = val & 16'h7FF;
                restart();
            end else if (idx == REG_SENS) begin
                sens_reg = val;
            end
        endfunction

        // Bit-serial integer square root, rounded down.
        function int unsigned root_floor(int unsigned x);
            int unsigned r, b;
            r = 0;
            b = 32'h4000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Masked 3x3 gradient, magnitude with 4 fraction bits, gain and saturation.
        function int unsigned gradient(int cl, int cc, int cr, bit left_ok, bit top_ok,
                                       bit bot_ok);
            int p[9];
            int gx, gy, r;
            bit row_ok;
            int unsigned g2, mag;
            longint unsigned scaled;
            for (r = 0; r < 3; r++) begin
                row_ok = (r == 1) || (r == 0 && top_ok) || (r == 2 && bot_ok);
                p[r*3]   = (row_ok && left_ok) ? win[r*3 + cl] : 0;
                p[r*3+1] = row_ok ? win[r*3 + cc] : 0;
                p[r*3+2] = (row_ok && cr >= 0) ? win[r*3 + (cr & 3)] : 0;
            end
            gx = -p[0] + p[2] - 2*p[3] + 2*p[5] - p[6] + p[8];
            gy = -p[0] - 2*p[1] - p[2] + p[6] + 2*p[7] + p[8];
            g2 = gx*gx + gy*gy;
            mag = root_floor(g2 << 8);
            scaled = (longint'(mag) * sens_reg + 2048) >> 12;
            return (scaled > 255) ? 255 : int'(scaled);
        endfunction

        // Advances the model by one accepted input transaction.
        function void note_item(logic [7:0] pix, logic flush);
            int unsigned w, h, ci, ri, co, edge_r, v;
            int ro, rr, r;
            bit emit, top_ok, bot_ok, last;
            t_edge_res res;
            w = eff_w();
            h = eff_h();
            v = flush ? 0 : pix;
            edge_r = 0;
            co = 0;
            ro = 0;
            if (flush) begin
                if (row < h) return;
            end else if (row >= h) begin
                if (!(row == h && col == 0)) fill = 0;
                row = 0;
                col = 0;
            end
            if (col >= w) col = 0;
            ci = col;
            ri = row;
            emit = fill > w;
            if (!emit) fill++;
            if (emit && ci == 0) begin
                ro = int'(ri) - 2;
                co = w - 1;
            end else if (emit) begin
                ro = int'(ri) - 1;
                co = ci - 1;
            end
            rr = ro;
            while (rr < 0) rr += int'(h);
            top_ok = rr >= 1;
            bot_ok = rr + 1 < h;
            if (emit && ci == 0) edge_r = gradient(1, 2, -1, w >= 2, top_ok, bot_ok);
            for (r = 0; r < 3; r++) begin
                win[r*3]   = win[r*3+1];
                win[r*3+1] = win[r*3+2];
            end
            win[2] = upper[ci];
            win[5] = middle[ci];
            win[8] = 8'(v);
            upper[ci] = middle[ci];
            middle[ci] = 8'(v);
            if (emit && ci != 0) edge_r = gradient(0, 1, 2, ci >= 2, top_ok, bot_ok);
            if (ci + 1 >= w) begin
                col = 0;
                row = ri + 1;
            end else begin
                col = ci + 1;
            end
            if (!emit) return;
            last = (rr == h - 1) && (co == w - 1);
            res.edge_v = 8'(edge_r);
            res.last = last;
            expected_q.insert(expected_q.size(), res);
            emitted = last ? 0 : ((emitted + 1) & 20'hFFFFF);
            if (last && ro >= 0) begin
                fill = 0;
                row = 0;
                col = 0;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        // Compares one accepted result with the oldest expectation.
        task check_result(logic [7:0] edge_v, logic last);
            t_edge_res exp_r;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result edge=%0d last=%0b", edge_v, last));
                return;
            end
            exp_r = expected_q.pop_front();
            if (edge_v !== exp_r.edge_v)
                report($sformatf("edge_value %0d, expected %0d", edge_v, exp_r.edge_v));
            if (last !== exp_r.last)
                report($sformatf("last_of_frame %0b, expected %0b", last, exp_r.last));
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_idx = REG_WIDTH;
    logic [SensW-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [PixW-1:0]  i_pixel_value = '0;
    logic             i_is_flush = 1'b0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [PixW-1:0]  o_edge_value;
    logic             o_last_of_frame;

    edge_scoreboard sb = new();
    int unsigned items_sent = 0;
    int unsigned frames_sent = 0;
    bit quiet = 1'b0;
    bit long_hold_req = 1'b0;
    int unsigned cur_w = 640, cur_h = 480;

    sobel_edge_magnitude_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pixel_value(i_pixel_value), .i_is_flush(i_is_flush),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_edge_value(o_edge_value), .o_last_of_frame(o_last_of_frame)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: random back-pressure bursts plus one long hold-off on request.
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) sb.check_result(o_edge_value, o_last_of_frame);
            if (hold > 0) begin
                hold--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LongHold;
            end else if (!quiet && $urandom_range(7) == 0) begin
                hold = $urandom_range(14, 1);
            end
            i_ready <= (hold == 0) && i_rst_n;
        end
    end

    // Watchdog on cycles without any accepted transaction or register write.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchLimit) begin
                $display("timeout: no transaction for %0d cycles", WatchLimit);
                $display("sobel_edge_magnitude_unit: mismatch");
                $finish;
            end
        end
    end

    // Offers one input transaction and waits until it is accepted.
    task send_item(logic [7:0] pix, logic flush);
        if (!quiet && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= pix;
        i_is_flush <= flush;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(pix, flush);
        items_sent++;
    endtask

    // Waits until every expected result has arrived, then lets the pipeline settle.
    task drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // One register write, after which the write enable returns low before the task ends.
    task write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.configure(idx, val);
        @(posedge i_clk);
    endtask

    task set_geometry(logic [15:0] w, logic [15:0] h, logic [15:0] sens);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SENS, sens);
        cur_w = sb.eff_w();
        cur_h = sb.eff_h();
    endtask

    function automatic logic [7:0] make_pixel(int unsigned mode, int unsigned idx);
        case (mode)
            0: return 8'd0;
            1: return 8'd255;
            2: return (idx[0] ^ idx[3]) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Sends one whole frame of pixels, optionally with stray early flushes.
    task send_frame(bit noisy);
        int unsigned n, mode;
        mode = $urandom_range(6);
        for (n = 0; n < cur_w * cur_h; n++) begin
            if (noisy && $urandom_range(15) == 0) send_item(8'($urandom_range(255)), 1'b1);
            send_item(make_pixel(mode, n), 1'b0);
        end
        frames_sent++;
    endtask

    task flush_out(int unsigned count);
        repeat (count) send_item(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin : stimulus
        int unsigned sens, phase, k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: small frame with full-scale gain and an early flush.
        set_geometry(3, 2, 16'hFFFF);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        flush_out(5);
        drain();

        // Directed: zero geometry (taken as one pixel), zero gain, unknown index.
        set_geometry(0, 0, 0);
        write_reg(RegUnused, 16'hFFFF);
        send_item(8'd255, 1'b0);
        flush_out(3);
        drain();
        write_reg(REG_SENS, 256);
        send_item(8'd128, 1'b0);
        send_item(8'd7, 1'b0);
        flush_out(3);
        drain();

        // Directed: pixel arriving after a partial flush drops the old results.
        set_geometry(2, 2, 300);
        for (k = 0; k < 4; k++) send_item(8'd255, 1'b0);
        flush_out(1);
        send_item(8'd9, 1'b0);
        flush_out(3);
        drain();

        // Random phases of geometry and gain.
        phase = 0;
        while (items_sent < 1000) begin
            phase++;
            case ($urandom_range(7))
                0: sens = 0;
                1: sens = 16'hFFFF;
                default: sens = $urandom_range(1024);
            endcase
            if (phase == 6) set_geometry(40, 1, 16'(sens));
            else if (phase == 9) set_geometry(1, 30, 16'(sens));
            else set_geometry(16'($urandom_range(8, 1)), 16'($urandom_range(6, 1)),
                              16'(sens));
            if (items_sent > 850) quiet = 1'b1;
            repeat ($urandom_range(3, 1)) begin
                if (phase == 4) long_hold_req = 1'b1;
                if (phase != 9 && $urandom_range(5) == 0) begin
                    send_frame(1'b1);
                    flush_out($urandom_range(cur_w, 1));
                end else begin
                    send_frame($urandom_range(3) == 0);
                    if (phase == 9) break;
                end
            end
            flush_out(cur_w + 3);
            drain();
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("Covered %0d input transactions in %0d frames, %0d results checked.",
                 items_sent, frames_sent, sb.results_seen);
        if (sb.errors == 0) begin
            $display("sobel_edge_magnitude_unit: match");
        end else begin
            $display("sobel_edge_magnitude_unit: mismatch");
        end
        $finish;
    end
endmodule

>>> sobel_edge_magnitude_unit.f
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_magnitude.sv
hdl/sobel_edge_magnitude_unit.sv
sim/sobel_edge_magnitude_unit_test.sv
